// ===== sv/mwo_pkg.sv =====
// Shared types, constants and tables of the multi-waveform oscillator.
// No dependencies; the queue, front, back and top-level files import this package.
`timescale 1ns / 1ps
package mwo_pkg;

	localparam int PH_W   = 32;
	localparam int SMP_W  = 16;
	localparam int TAB_Q  = 256;
	localparam int N_HARM = 16;
	localparam int HARM_W = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int RECIP_SH   = 21;

	typedef enum logic [2:0] {
		WF_SINE     = 3'd0,
		WF_TRIANGLE = 3'd1,
		WF_SAW      = 3'd2,
		WF_TRAP     = 3'd3,
		WF_SQUARE   = 3'd4,
		WF_PHASOR   = 3'd5,
		WF_HANN     = 3'd6,
		WF_PULSE    = 3'd7
	} wave_t;

	localparam logic [1:0] CFG_WAVEFORM = 2'd0;
	localparam logic [1:0] CFG_OFFSET   = 2'd1;
	localparam logic [1:0] CFG_PWIDTH   = 2'd2;

	localparam logic [15:0] PWIDTH_RST = 16'd6554;

	typedef struct packed {
		logic [PH_W-1:0] phase;
		logic            neg;
	} item_t;

	typedef logic [15:0] qtab_t [0:TAB_Q];

	function automatic longint mul30(longint a, longint b);
		longint p;
		p = a * b;
		return (p < 0) ? -((-p) >>> 30) : (p >>> 30);
	endfunction

	function automatic qtab_t build_qtab();
		qtab_t  tab;
		longint t, t2, s, v;
		for (int k = 0; k <= TAB_Q; k++) begin
			t  = longint'(k) <<< 22;
			t2 = mul30(t, t);
			s  = 172272;
			s  = -5026995 + mul30(t2, s);
			s  = 85569305 + mul30(t2, s);
			s  = -693598668 + mul30(t2, s);
			s  = 1686629713 + mul30(t2, s);
			s  = mul30(t, s);
			if (s < 0) s = 0;
			v = (s * 32767 + (longint'(1) <<< 29)) >>> 30;
			if (v > 32767) v = 32767;
			tab[k] = v[15:0];
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	// ceil(2^21 / m) for odd m = 1..31; exact floor division of 15-bit values
	localparam logic [21:0] RECIP [0:N_HARM-1] = '{
		22'd2097152, 22'd699051, 22'd419431, 22'd299594,
		22'd233017,  22'd190651, 22'd161320, 22'd139811,
		22'd123362,  22'd110377, 22'd99865,  22'd91181,
		22'd83887,   22'd77673,  22'd72316,  22'd67651
	};

	function automatic logic signed [15:0] table_sine(input logic [PH_W-1:0] p);
		logic [9:0] idx;
		logic [8:0] j;
		logic signed [15:0] v;
		idx = p[PH_W-1 -: 10];
		j   = {1'b0, idx[7:0]};
		if (idx[8]) j = 9'd256 - j;
		v = signed'(QTAB[j]);
		return idx[9] ? -v : v;
	endfunction

endpackage

// ===== sv/mwo_if.sv =====
// Valid/ready channel interfaces for the oscillator's request and sample streams.
// Depends on nothing.
`timescale 1ns / 1ps
interface mwo_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] phase_step;
	modport source(output valid, output phase_step, input ready);
	modport sink(input valid, input phase_step, output ready);
endinterface

interface mwo_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

// ===== sv/mwo_fifo.sv =====
// Short queue of classified requests between the front and the back part.
// Depends on mwo_pkg.
`timescale 1ns / 1ps
module mwo_fifo
	import mwo_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	input  logic  pop,
	output item_t rdata,
	output logic  full,
	output logic  empty
);
	item_t              mem_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

// ===== sv/mwo_front.sv =====
// Front part: accepts phase steps, holds the phase accumulator, queues requests.
// Depends on mwo_pkg and mwo_fifo.
`timescale 1ns / 1ps
module mwo_front
	import mwo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] step,
	input  wave_t       wf,
	input  logic        pop,
	output item_t       item,
	output logic        empty
);
	logic [PH_W-1:0] phase_q;
	logic [PH_W-1:0] delta;
	logic            full, push, neg, inverted;
	item_t           wdata;

	assign in_ready = !full;
	assign push     = in_valid && in_ready;
	assign neg      = step[31];
	assign inverted = neg && (wf == WF_SAW || wf == WF_PHASOR);
	// inverted shapes advance by the magnitude of the step
	assign delta    = inverted ? (~step + 1'b1) : step;
	assign wdata    = '{phase: phase_q, neg: neg};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) phase_q <= '0;
		else if (push) phase_q <= phase_q + delta;
	end

	mwo_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wdata),
		.pop   (pop),
		.rdata (item),
		.full  (full),
		.empty (empty)
	);
endmodule

// ===== sv/mwo_back.sv =====
// Back part: evaluates the selected waveform for each queued request.
// Sine lookups and the harmonic sum run through a three-step pipeline. Depends on mwo_pkg.
`timescale 1ns / 1ps
module mwo_back
	import mwo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  wave_t       wf,
	input  logic [15:0] offset,
	input  logic [15:0] pwidth,
	input  item_t       item,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_sample
);
	localparam logic signed [15:0] SMAX = 16'sd32767;
	localparam logic signed [15:0] SMIN = -16'sd32768;

	function automatic logic signed [15:0] sat21(input logic signed [20:0] v);
		if (v > 21'sd32767) return SMAX;
		if (v < -21'sd32768) return SMIN;
		return v[15:0];
	endfunction

	// issue stage
	logic              busy_q;
	logic [PH_W-1:0]   lk_ph_q, step_q;
	logic [HARM_W-1:0] cnt_q, last_idx_q;
	wave_t             wf_q;
	logic signed [15:0] val_q;

	// pipeline
	logic              valid_s1, last_s1, first_s1;
	logic [HARM_W-1:0] idx_s1;
	logic signed [15:0] sin_s1, val_s1;
	wave_t             wf_s1;
	logic              valid_s2, last_s2, first_s2, neg_s2;
	logic [36:0]       prod_s2;
	logic signed [15:0] val_s2;
	wave_t             wf_s2;
	logic signed [20:0] sum_q;

	logic              out_valid_q;
	logic [15:0]       out_q;

	logic [PH_W-1:0]   pp;
	logic [15:0]       u;
	logic signed [17:0] u18, dv;
	logic signed [15:0] direct;
	logic              stall;
	logic [14:0]       mag_s1, quo;
	logic signed [20:0] term, sum_next;
	logic signed [15:0] final_v;
	logic signed [16:0] hann;

	assign pp  = item.phase + {offset, 16'd0};
	assign u   = pp[PH_W-1 -: 16];
	assign u18 = signed'({2'b00, u});

	always_comb begin
		dv = '0;
		case (wf)
			WF_TRIANGLE: begin
				if (u < 16'd16384) dv = 18'sd2 * u18;
				else if (u < 16'd49152) dv = 18'sd65536 - 18'sd2 * u18;
				else dv = 18'sd2 * u18 - 18'sd131072;
			end
			WF_SAW:    dv = item.neg ? (18'sd32768 - u18) : (u18 - 18'sd32768);
			WF_SQUARE: begin
				if (pp[PH_W-2:0] == '0) dv = '0;
				else dv = pp[PH_W-1] ? 18'(SMIN) : 18'(SMAX);
			end
			WF_PHASOR: dv = item.neg ? ((18'sd65536 - u18) >>> 1) : (u18 >>> 1);
			WF_PULSE:  dv = (item.phase <= {pwidth, 16'd0}) ? 18'(SMIN) : 18'sd0;
			default:   dv = '0;
		endcase
		direct = sat21(21'(dv));
	end

	assign pop = !busy_q && !empty;

	assign mag_s1   = sin_s1[15] ? 15'(-sin_s1) : sin_s1[14:0];
	assign quo      = prod_s2[35:RECIP_SH];
	assign term     = neg_s2 ? -21'(signed'({1'b0, quo})) : 21'(signed'({1'b0, quo}));
	assign sum_next = (first_s2 ? 21'sd0 : sum_q) + term;
	// 32768 - sine spans 1..65535, so keep it unsigned before halving
	assign hann     = (17'd32768 - sum_next[16:0]) >> 1;

	always_comb begin
		case (wf_s2)
			WF_SINE: final_v = sum_next[15:0];
			WF_TRAP: final_v = sat21(sum_next);
			WF_HANN: final_v = hann[15:0];
			default: final_v = val_s2;
		endcase
	end

	// hold the whole pipeline while a finished sample cannot enter the output register
	assign stall = valid_s2 && last_s2 && out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) busy_q <= 1'b1;
			else if (busy_q && !stall && cnt_q == last_idx_q) busy_q <= 1'b0;
			if (!stall) begin
				valid_s1 <= busy_q;
				valid_s2 <= valid_s1;
			end
			if (valid_s2 && last_s2 && !stall) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			wf_q       <= wf;
			val_q      <= direct;
			cnt_q      <= '0;
			last_idx_q <= (wf == WF_TRAP) ? HARM_W'(N_HARM-1) : '0;
			step_q     <= {item.phase[PH_W-2:0], 1'b0};
			case (wf)
				WF_SINE: lk_ph_q <= item.phase;
				WF_HANN: lk_ph_q <= pp + {2'b01, {(PH_W-2){1'b0}}};
				default: lk_ph_q <= pp;
			endcase
		end else if (busy_q && !stall) begin
			lk_ph_q <= lk_ph_q + step_q;
			cnt_q   <= cnt_q + 1'b1;
		end
		if (!stall) begin
			sin_s1   <= table_sine(lk_ph_q);
			idx_s1   <= cnt_q;
			first_s1 <= (cnt_q == '0);
			last_s1  <= (cnt_q == last_idx_q);
			val_s1   <= val_q;
			wf_s1    <= wf_q;
			prod_s2  <= 37'(mag_s1) * 37'(RECIP[idx_s1]);
			neg_s2   <= sin_s1[15];
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			val_s2   <= val_s1;
			wf_s2    <= wf_s1;
			if (valid_s2) sum_q <= sum_next;
		end
		if (valid_s2 && last_s2 && !stall) out_q <= final_v;
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_q;
endmodule

// ===== sv/multi_waveform_oscillator_core.sv =====
// Top level of the multi-waveform oscillator: configuration registers, front and back part.
// Depends on mwo_pkg, mwo_if, mwo_front and mwo_back.
//
// Usage: each request on in_ch carries one signed phase step; each request yields exactly
// one Q1.15 sample on out_ch, in order, taken from the phase held before the step.
// Registers are written through cfg_we/cfg_idx/cfg_data (0 waveform, 1 phase offset,
// 2 pulse width) while no request is in flight; other indexes are ignored.
// The front part advances the phase accumulator in the cycle a request is accepted and
// queues it (four entries), so in_ch accepts one request per cycle while the queue has room.
// The back part issues the lookups of one request at a time and pops the next request
// once the last lookup is issued; the trapezoid's sixteen harmonics share one sine table
// lookup, one per cycle while out_ch does not stall, and that lookup sets the sustained
// rate. Each request passes the issue registers, stages s1 and s2 and the output register.
// Reset clears the phase, the queue and the pipeline; waveform resets to sine, offset to 0
// and pulse width to 6554. When out_ch stalls, the sample holds in the output register,
// the back part keeps working until its next sample is ready, and the queue then fills
// until in_ch deasserts ready.
`timescale 1ns / 1ps
module multi_waveform_oscillator_core
	import mwo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data,
	mwo_in_if.sink      in_ch,
	mwo_out_if.source   out_ch
);
	wave_t       wf_q;
	logic [15:0] off_q, pw_q;
	item_t       item;
	logic        pop, empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wf_q  <= WF_SINE;
			off_q <= '0;
			pw_q  <= PWIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WAVEFORM: wf_q  <= wave_t'(cfg_data[2:0]);
				CFG_OFFSET:   off_q <= cfg_data;
				CFG_PWIDTH:   pw_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	mwo_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.step    (in_ch.phase_step),
		.wf      (wf_q),
		.pop     (pop),
		.item    (item),
		.empty   (empty)
	);

	mwo_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wf        (wf_q),
		.offset    (off_q),
		.pwidth    (pw_q),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_sample(out_ch.sample)
	);
endmodule

// ===== sv/mwo_checker.sv =====
// Port-level checks of the oscillator, bound to the top level.
// Depends on the ports of multi_waveform_oscillator_core.
`timescale 1ns / 1ps
module mwo_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_sample
);
	logic [3:0] open_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// count requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) open_q <= '0;
		else if (in_acc && !out_acc) open_q <= open_q + 1'b1;
		else if (out_acc && !in_acc) open_q <= open_q - 1'b1;
	end

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != 4'd0) else $error("sample without pending request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 4'd8) else $error("more requests in flight than storage");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		open_q == 4'd0 |-> in_ready) else $error("idle block refuses requests");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample))
		else $error("stalled sample dropped or changed");
endmodule

bind multi_waveform_oscillator_core mwo_checker u_mwo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_sample(out_ch.sample)
);
